// ===== sv/lru_pkg.sv =====
// Package with the shared types and constants of the LRU cache table.
package lru_pkg;

    localparam int REQ_GET = 0;
    localparam int REQ_PUT = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_EVICT,
        ST_INSERT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic        hit;
        logic [7:0]  found_type;
        logic [31:0] found_handle;
        logic [15:0] found_length;
        logic [31:0] found_time;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_result;

    typedef struct packed {
        logic [7:0]  type_code;
        logic [31:0] content_handle;
        logic [15:0] body_length;
        logic [31:0] created_time;
    } t_payload;

    localparam logic [1:0] REG_CAPACITY = 2'd0;

endpackage

// ===== sv/lru_if.sv =====
// Valid/ready channel interfaces for the request and the result.
interface lru_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] key;
    logic [7:0]  type_code;
    logic [31:0] content_handle;
    logic [15:0] body_length;
    logic [31:0] created_time;
    modport source (output valid, req_type, key, type_code, content_handle,
                    body_length, created_time, input ready);
    modport sink (input valid, req_type, key, type_code, content_handle,
                  body_length, created_time, output ready);
endinterface

interface lru_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [7:0]  found_type;
    logic [31:0] found_handle;
    logic [15:0] found_length;
    logic [31:0] found_time;
    logic        evicted;
    logic [31:0] evicted_key;
    modport source (output valid, hit, found_type, found_handle, found_length,
                    found_time, evicted, evicted_key, input ready);
    modport sink (input valid, hit, found_type, found_handle, found_length,
                  found_time, evicted, evicted_key, output ready);
endinterface

// ===== sv/lru_cache_table.sv =====
// Top level of the LRU cache table: register file entries, search sequencer and APB port.
//
//  channel   | dir | transfer when      | content
//  i_req     | in  | valid && ready     | req_type, key, payload
//  o_rsp     | out | valid && ready     | hit, found payload, evicted key
//  APB       | in  | psel&penable&pwrite| capacity register
//
// A get miss passes through idle, one search step per slot through a single
// comparator, update and result. A put of a new key adds an insert state, an
// eviction one more; a hit ends the search at its slot.
// Reset (synchronous, active low) clears valid bits, the MRU/LRU pointers and count.
// A request is taken only in idle; a result waiting on o_rsp.ready holds the block.
module lru_cache_table #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lru_req_if.sink     i_req,
    lru_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    lru_pkg::t_state r_state, n_state;

    logic [4:0]          r_capacity;
    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_BITS-1:0] r_keys  [ENTRIES];
    lru_pkg::t_payload   r_pay   [ENTRIES];
    logic [SW-1:0]       r_newer [ENTRIES];
    logic [SW-1:0]       r_older [ENTRIES];
    logic [SW-1:0]       r_mru, r_lru;
    logic [CW-1:0]       r_count;

    logic [SW:0]         r_idx;
    logic                r_found;
    logic [SW-1:0]       r_slot;
    logic                r_put;
    logic [KEY_BITS-1:0] r_key;
    lru_pkg::t_payload   r_in;
    lru_pkg::t_result    r_res;

    logic [CW-1:0] w_cap;
    logic [5:0]    w_capx;
    logic          w_hit_now;
    logic          w_free_ok;
    logic [SW-1:0] w_free;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr == lru_pkg::REG_CAPACITY) ? {27'd0, r_capacity} : 32'd0;

    // Clamp capacity into 1..ENTRIES.
    always_comb begin
        w_capx = {1'b0, r_capacity};
        if (w_capx == 6'd0) begin
            w_capx = 6'd1;
        end
        if (32'(w_capx) > ENTRIES) begin
            w_cap = CW'(ENTRIES);
        end else begin
            w_cap = CW'(w_capx);
        end
    end

    // One comparator, stepped over the slots.
    assign w_hit_now = r_valid[r_idx[SW-1:0]] && (r_keys[r_idx[SW-1:0]] == r_key);

    // Lowest invalid slot (priority over valid bits).
    always_comb begin
        w_free_ok = 1'b0;
        w_free    = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_ok = 1'b1;
                w_free    = SW'(i);
            end
        end
    end

    assign i_req.ready = (r_state == lru_pkg::ST_IDLE);
    assign o_rsp.valid = (r_state == lru_pkg::ST_RESULT);
    assign o_rsp.hit          = r_res.hit;
    assign o_rsp.found_type   = r_res.found_type;
    assign o_rsp.found_handle = r_res.found_handle;
    assign o_rsp.found_length = r_res.found_length;
    assign o_rsp.found_time   = r_res.found_time;
    assign o_rsp.evicted      = r_res.evicted;
    assign o_rsp.evicted_key  = r_res.evicted_key;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lru_pkg::ST_IDLE:   if (i_req.valid) n_state = lru_pkg::ST_SEARCH;
            lru_pkg::ST_SEARCH: begin
                if (w_hit_now || r_idx == (SW + 1)'(ENTRIES - 1)) begin
                    n_state = lru_pkg::ST_UPDATE;
                end
            end
            lru_pkg::ST_UPDATE: begin
                if (r_found || !r_put) begin
                    n_state = lru_pkg::ST_RESULT;
                end else if (r_count >= w_cap && r_count != '0) begin
                    n_state = lru_pkg::ST_EVICT;
                end else begin
                    n_state = lru_pkg::ST_INSERT;
                end
            end
            lru_pkg::ST_EVICT:  n_state = lru_pkg::ST_INSERT;
            lru_pkg::ST_INSERT: n_state = lru_pkg::ST_RESULT;
            lru_pkg::ST_RESULT: if (o_rsp.ready) n_state = lru_pkg::ST_IDLE;
            default:            n_state = lru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lru_pkg::ST_IDLE;
            r_capacity <= 5'd16;
            r_valid    <= '0;
            r_mru      <= '0;
            r_lru      <= '0;
            r_count    <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr == lru_pkg::REG_CAPACITY) begin
                r_capacity <= pwdata[4:0];
            end
            unique case (r_state)
                lru_pkg::ST_IDLE: begin
                    if (i_req.valid) begin
                        r_put   <= i_req.req_type;
                        r_key   <= KEY_BITS'(i_req.key);
                        r_in    <= {i_req.type_code, i_req.content_handle,
                                    i_req.body_length, i_req.created_time};
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_res   <= '0;
                    end
                end
                lru_pkg::ST_SEARCH: begin
                    if (w_hit_now) begin
                        r_found <= 1'b1;
                        r_slot  <= r_idx[SW-1:0];
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                lru_pkg::ST_UPDATE: begin
                    if (r_found) begin
                        if (r_put) begin
                            r_pay[r_slot] <= r_in;
                        end else begin
                            r_res.hit          <= 1'b1;
                            r_res.found_type   <= r_pay[r_slot].type_code;
                            r_res.found_handle <= r_pay[r_slot].content_handle;
                            r_res.found_length <= r_pay[r_slot].body_length;
                            r_res.found_time   <= r_pay[r_slot].created_time;
                        end
                        // Move to front unless the slot already is the most recent.
                        if (r_slot != r_mru) begin
                            if (r_slot == r_lru) begin
                                r_lru <= r_newer[r_slot];
                            end else begin
                                r_older[r_newer[r_slot]] <= r_older[r_slot];
                                r_newer[r_older[r_slot]] <= r_newer[r_slot];
                            end
                            r_newer[r_mru]  <= r_slot;
                            r_older[r_slot] <= r_mru;
                            r_mru           <= r_slot;
                        end
                    end
                end
                lru_pkg::ST_EVICT: begin
                    r_res.evicted     <= 1'b1;
                    r_res.evicted_key <= 32'(r_keys[r_lru]);
                    if (r_lru != r_mru) begin
                        r_lru <= r_newer[r_lru];
                    end
                    r_valid[r_lru] <= 1'b0;
                    r_count        <= r_count - 1'b1;
                end
                lru_pkg::ST_INSERT: begin
                    if (w_free_ok) begin
                        r_valid[w_free] <= 1'b1;
                        r_keys[w_free]  <= r_key;
                        r_pay[w_free]   <= r_in;
                        r_count         <= r_count + 1'b1;
                        if (r_count == '0) begin
                            r_lru <= w_free;
                        end else begin
                            r_newer[r_mru]  <= w_free;
                            r_older[w_free] <= r_mru;
                        end
                        r_mru <= w_free;
                    end
                end
                lru_pkg::ST_RESULT: ;
                default: ;
            endcase
        end
    end
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the LRU cache table: random requests and a recency predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              req_type;
        logic [31:0]       key;
        lru_pkg::t_payload pay;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lru_req_if req_ch ();
    lru_rsp_if rsp_ch ();

    lru_cache_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: the cache contents and recency order, most recent first.
    logic [31:0]       cache_keys[$];
    lru_pkg::t_payload cache_pay[$];
    int                cap_setting;

    t_request          pending_reqs[$];
    lru_pkg::t_result  expected_results[$];
    int                error_count;
    int                hold_cycles;
    int                req_gap;
    int                rsp_gap;
    logic              req_accepted;
    logic              rsp_accepted;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic lru_pkg::t_result predict_lookup(t_request r);
        lru_pkg::t_result res;
        int      idx;
        int      lim;
        res = '0;
        idx = -1;
        foreach (cache_keys[i]) if (cache_keys[i] == r.key) idx = i;
        lim = (cap_setting == 0) ? 1 : (cap_setting > 16 ? 16 : cap_setting);
        if (r.req_type == lru_pkg::REQ_GET[0]) begin
            if (idx >= 0) begin
                res.hit          = 1'b1;
                res.found_type   = cache_pay[idx].type_code;
                res.found_handle = cache_pay[idx].content_handle;
                res.found_length = cache_pay[idx].body_length;
                res.found_time   = cache_pay[idx].created_time;
                cache_keys.push_front(cache_keys[idx]);
                cache_pay.push_front(cache_pay[idx]);
                cache_keys.delete(idx + 1);
                cache_pay.delete(idx + 1);
            end
        end else begin
            if (idx >= 0) begin
                cache_keys.delete(idx);
                cache_pay.delete(idx);
            end else if (cache_keys.size() >= lim) begin
                res.evicted     = 1'b1;
                res.evicted_key = cache_keys.pop_back();
                void'(cache_pay.pop_back());
            end
            cache_keys.push_front(r.key);
            cache_pay.push_front(r.pay);
        end
        return res;
    endfunction

    // Driver: requests change on the falling edge, gaps drawn per item.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_gap      <= 0;
        end else if (req_ch.valid && !req_accepted) begin
        end else if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap      <= req_gap - 1;
        end else if (pending_reqs.size() > 0) begin
            t_request r;
            r = pending_reqs.pop_front();
            req_ch.valid          <= 1'b1;
            req_ch.req_type       <= r.req_type;
            req_ch.key            <= r.key;
            req_ch.type_code      <= r.pay.type_code;
            req_ch.content_handle <= r.pay.content_handle;
            req_ch.body_length    <= r.pay.body_length;
            req_ch.created_time   <= r.pay.created_time;
            req_gap               <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // Prediction happens when the request transfer is seen at the rising edge.
    always @(posedge i_clk) begin
        req_accepted <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            t_request r;
            r.req_type = req_ch.req_type;
            r.key      = req_ch.key;
            r.pay      = '{req_ch.type_code, req_ch.content_handle,
                           req_ch.body_length, req_ch.created_time};
            expected_results.push_back(predict_lookup(r));
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_gap      <= 0;
        end else if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_accepted) begin
            rsp_gap      <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            rsp_ch.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_gap      <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Monitor: compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        rsp_accepted <= i_rst_n && rsp_ch.valid && rsp_ch.ready;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            lru_pkg::t_result w;
            if (expected_results.size() == 0) begin
                $display("%0t result with nothing expected", $realtime);
                error_count++;
            end else begin
                w = expected_results.pop_front();
                if (rsp_ch.hit !== w.hit) report_mismatch("hit", rsp_ch.hit, w.hit);
                if (rsp_ch.found_type !== w.found_type)
                    report_mismatch("found_type", rsp_ch.found_type, w.found_type);
                if (rsp_ch.found_handle !== w.found_handle)
                    report_mismatch("found_handle", rsp_ch.found_handle, w.found_handle);
                if (rsp_ch.found_length !== w.found_length)
                    report_mismatch("found_length", rsp_ch.found_length, w.found_length);
                if (rsp_ch.found_time !== w.found_time)
                    report_mismatch("found_time", rsp_ch.found_time, w.found_time);
                if (rsp_ch.evicted !== w.evicted)
                    report_mismatch("evicted", rsp_ch.evicted, w.evicted);
                if (rsp_ch.evicted_key !== w.evicted_key)
                    report_mismatch("evicted_key", rsp_ch.evicted_key, w.evicted_key);
            end
        end
    end

    // Long receiver hold-off, counted down in its own process.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    task automatic write_capacity(input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= lru_pkg::REG_CAPACITY;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_setting = value & 31;
    endtask

    task automatic add_request(input logic rt, input logic [31:0] k,
                               input lru_pkg::t_payload p);
        t_request r;
        r.req_type = rt;
        r.key      = k;
        r.pay      = p;
        pending_reqs.push_back(r);
    endtask

    function automatic lru_pkg::t_payload random_payload();
        return '{8'($urandom_range(0, 255)), $urandom,
                 16'($urandom_range(0, 65535)), $urandom};
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_reqs.size() > 0 || expected_results.size() > 0 || req_ch.valid)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    // A phase of random traffic over a small key pool so hits and evictions are common.
    task automatic random_phase(input int count, input int pool);
        logic [31:0] base;
        base = $urandom;
        for (int n = 0; n < count; n++) begin
            logic [31:0] k;
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = base ^ ($urandom_range(0, pool - 1) << $urandom_range(0, 28));
            add_request(1'($urandom_range(0, 1)), k, random_payload());
        end
    endtask

    initial begin
        int caps[8];
        error_count = 0;
        hold_cycles = 0;
        cap_setting = 16;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.key = '0;
        req_ch.type_code = '0;
        req_ch.content_handle = '0;
        req_ch.body_length = '0;
        req_ch.created_time = '0;
        rsp_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: miss on empty, field extremes, update of a present key, hits.
        add_request(lru_pkg::REQ_GET[0], 32'h0, '0);
        add_request(lru_pkg::REQ_PUT[0], 32'h0, '0);
        add_request(lru_pkg::REQ_PUT[0], 32'hFFFF_FFFF,
                    '{8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF});
        add_request(lru_pkg::REQ_GET[0], 32'hFFFF_FFFF, random_payload());
        add_request(lru_pkg::REQ_GET[0], 32'h0, random_payload());
        add_request(lru_pkg::REQ_PUT[0], 32'h0,
                    '{8'hA5, 32'h1234_5678, 16'h55AA, 32'hDEAD_BEEF});
        add_request(lru_pkg::REQ_GET[0], 32'h0, '0);
        for (int i = 1; i <= 16; i++)
            add_request(lru_pkg::REQ_PUT[0], i * 32'h1111, random_payload());
        add_request(lru_pkg::REQ_GET[0], 32'h5555, '0);
        add_request(lru_pkg::REQ_PUT[0], 32'h8000_0000, random_payload());
        drain();

        // Capacity zero behaves as one, above sixteen as sixteen; includes both extremes.
        caps = '{0, 1, 31, 2, 17, 5, 16, 3};
        foreach (caps[c]) begin
            write_capacity(caps[c]);
            random_phase(220, (caps[c] > 8) ? 24 : 6);
            if (c == 3) begin
                // Keep the receiver off while requests keep coming so the block stalls.
                @(negedge i_clk);
                hold_cycles <= 300;
            end
            drain();
        end

        if (expected_results.size() != 0 || pending_reqs.size() != 0) begin
            $display("%0d expected results never arrived, %0d requests never sent",
                     expected_results.size(), pending_reqs.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/lru_pkg.sv
sv/lru_if.sv
sv/lru_cache_table.sv
verif/tb.sv
